// ===== design/fat12_pkg.sv =====
package fat12_pkg;

  // Table geometry
  localparam int CLUSTER_COUNT      = 2880;
  localparam int ENTRY_W            = 12;
  localparam int IDX_W              = $clog2(CLUSTER_COUNT);
  localparam int CNT_W              = $clog2(CLUSTER_COUNT + 1);
  localparam int FIRST_DATA_CLUSTER = 2;

  localparam logic [ENTRY_W-1:0] MARK_IN_USE = 12'hff0;
  localparam logic [ENTRY_W-1:0] MARK_END    = 12'hfff;
  localparam logic [ENTRY_W:0]   COUNT_WIDE  = (ENTRY_W + 1)'(CLUSTER_COUNT);

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_ALLOC = 2'd2,
    KIND_CLOSE = 2'd3
  } kind_e;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ,
    OP_READ_DONE,
    OP_SCAN_START,
    OP_SCAN_STEP,
    OP_FULL,
    OP_LINK,
    OP_MARK,
    OP_CLOSE,
    OP_EMIT
  } op_e;

  // Jump conditions: taken -> target (target + kind for CND_KIND), otherwise step + 1
  typedef enum logic [2:0] {
    CND_NEXT,
    CND_ALWAYS,
    CND_NO_ITEM,
    CND_KIND,
    CND_MISS_MORE,
    CND_HIT,
    CND_OUT_BUSY
  } cond_e;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE      = 4'd0;
  localparam step_t ST_DISP      = 4'd1;
  localparam step_t ST_WRITE     = 4'd2;  // ST_WRITE + kind selects the item routine
  localparam step_t ST_READ      = 4'd3;
  localparam step_t ST_ALLOC     = 4'd4;
  localparam step_t ST_CLOSE     = 4'd5;
  localparam step_t ST_READ_DONE = 4'd6;
  localparam step_t ST_SCAN      = 4'd7;
  localparam step_t ST_SCAN_END  = 4'd8;
  localparam step_t ST_FULL      = 4'd9;
  localparam step_t ST_LINK      = 4'd10;
  localparam step_t ST_MARK      = 4'd11;
  localparam step_t ST_EMIT      = 4'd15;  // falls through to ST_IDLE by wrap

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    kind_e kind;
    logic  miss_more;
    logic  hit;
  } dp_status_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] value;
    logic               start;
    logic               full;
  } result_t;

  // Control store
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    unique case (s)
      ST_IDLE:      w = '{op: OP_NONE,       cond: CND_NO_ITEM,   target: ST_IDLE};
      ST_DISP:      w = '{op: OP_NONE,       cond: CND_KIND,      target: ST_WRITE};
      ST_WRITE:     w = '{op: OP_WRITE,      cond: CND_ALWAYS,    target: ST_EMIT};
      ST_READ:      w = '{op: OP_READ,       cond: CND_ALWAYS,    target: ST_READ_DONE};
      ST_ALLOC:     w = '{op: OP_SCAN_START, cond: CND_ALWAYS,    target: ST_SCAN};
      ST_CLOSE:     w = '{op: OP_CLOSE,      cond: CND_ALWAYS,    target: ST_EMIT};
      ST_READ_DONE: w = '{op: OP_READ_DONE,  cond: CND_ALWAYS,    target: ST_EMIT};
      ST_SCAN:      w = '{op: OP_SCAN_STEP,  cond: CND_MISS_MORE, target: ST_SCAN};
      ST_SCAN_END:  w = '{op: OP_NONE,       cond: CND_HIT,       target: ST_LINK};
      ST_FULL:      w = '{op: OP_FULL,       cond: CND_ALWAYS,    target: ST_EMIT};
      ST_LINK:      w = '{op: OP_LINK,       cond: CND_NEXT,      target: ST_IDLE};
      ST_MARK:      w = '{op: OP_MARK,       cond: CND_ALWAYS,    target: ST_EMIT};
      ST_EMIT:      w = '{op: OP_EMIT,       cond: CND_OUT_BUSY,  target: ST_EMIT};
      default:      w = '{op: OP_NONE,       cond: CND_ALWAYS,    target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== design/fat12_ram.sv =====
module fat12_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2880
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fat12_useq.sv =====
module fat12_useq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_busy_i,
  input  fat12_pkg::dp_status_t status_i,
  output fat12_pkg::op_e        op_o,
  output logic                 idle_o
);
  import fat12_pkg::*;

  step_t  step_q, step_d;
  ucode_t uc;
  logic   take;

  assign uc = ucode_rom(step_q);

  always_comb begin
    unique case (uc.cond)
      CND_NEXT:      take = 1'b0;
      CND_ALWAYS:    take = 1'b1;
      CND_NO_ITEM:   take = !in_valid_i;
      CND_KIND:      take = 1'b1;
      CND_MISS_MORE: take = status_i.miss_more;
      CND_HIT:       take = status_i.hit;
      CND_OUT_BUSY:  take = out_busy_i;
      default:       take = 1'b1;
    endcase

    if (!take) begin
      step_d = step_q + step_t'(1);
    end else if (uc.cond == CND_KIND) begin
      step_d = uc.target + step_t'(status_i.kind);
    end else begin
      step_d = uc.target;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign op_o   = uc.op;
  assign idle_o = (step_q == ST_IDLE);

`ifndef SYNTHESIS
  a_scan_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == ST_SCAN |=> step_q == ST_SCAN || step_q == ST_SCAN_END)
    else $error("scan loop left to an unexpected step");

  a_emit_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == ST_EMIT && !out_busy_i |=> step_q == ST_IDLE)
    else $error("emit did not return to idle");
`endif

endmodule

// ===== design/fat12_dpath.sv =====
module fat12_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             capture_i,
  input  logic [1:0]                       kind_i,
  input  logic [fat12_pkg::ENTRY_W-1:0]    entry_index_i,
  input  logic [fat12_pkg::ENTRY_W-1:0]    entry_value_i,
  input  fat12_pkg::op_e                   op_i,
  output fat12_pkg::dp_status_t            status_o,
  output fat12_pkg::result_t               result_o
);
  import fat12_pkg::*;

  kind_e              kind_q;
  logic [ENTRY_W-1:0] idx_q;
  logic [ENTRY_W-1:0] val_q;
  logic [CNT_W-1:0]   scan_q, scan_d;
  logic [IDX_W-1:0]   last_q, last_d;
  logic               open_q, open_d;
  result_t            res_q, res_d;

  logic               in_range;
  logic [CNT_W-1:0]   found_cnt;
  logic [IDX_W-1:0]   found;
  logic               miss_more;
  logic               hit;

  logic               we, re;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;

  assign in_range  = {1'b0, idx_q} < COUNT_WIDE;
  assign found_cnt = scan_q - CNT_W'(1);
  assign found     = found_cnt[IDX_W-1:0];
  assign hit       = (rdata == '0);
  assign miss_more = !hit && (scan_q != CNT_W'(CLUSTER_COUNT));

  always_comb begin
    we     = 1'b0;
    re     = 1'b0;
    waddr  = last_q;
    raddr  = idx_q[IDX_W-1:0];
    wdata  = val_q;
    scan_d = scan_q;
    last_d = last_q;
    open_d = open_q;
    res_d  = res_q;

    unique case (op_i)
      OP_WRITE: begin
        we    = in_range;
        waddr = idx_q[IDX_W-1:0];
        res_d = '0;
      end
      OP_READ: begin
        re = in_range;
      end
      OP_READ_DONE: begin
        res_d       = '0;
        res_d.value = in_range ? rdata : '0;
      end
      OP_SCAN_START: begin
        re     = 1'b1;
        raddr  = IDX_W'(FIRST_DATA_CLUSTER);
        scan_d = CNT_W'(FIRST_DATA_CLUSTER + 1);
      end
      OP_SCAN_STEP: begin
        // advance only while the entry under test is taken and more remain
        re    = miss_more;
        raddr = scan_q[IDX_W-1:0];
        if (miss_more) begin
          scan_d = scan_q + CNT_W'(1);
        end
      end
      OP_FULL: begin
        res_d      = '0;
        res_d.full = 1'b1;
      end
      OP_LINK: begin
        we    = open_q;
        waddr = last_q;
        wdata = ENTRY_W'(found);
        res_d = '0;
        if (!open_q) begin
          res_d.start = 1'b1;
          open_d      = 1'b1;
        end
      end
      OP_MARK: begin
        we          = 1'b1;
        waddr       = found;
        wdata       = MARK_IN_USE;
        last_d      = found;
        res_d.value = ENTRY_W'(found);
      end
      OP_CLOSE: begin
        we     = open_q;
        waddr  = last_q;
        wdata  = MARK_END;
        open_d = 1'b0;
        last_d = '0;
        res_d  = '0;
      end
      OP_NONE, OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  fat12_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CLUSTER_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      open_q <= 1'b0;
    end else begin
      last_q <= last_d;
      open_q <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      kind_q <= kind_e'(kind_i);
      idx_q  <= entry_index_i;
      val_q  <= entry_value_i;
    end
    scan_q <= scan_d;
    res_q  <= res_d;
  end

  assign status_o = '{kind: kind_q, miss_more: miss_more, hit: hit};
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_SCAN_STEP |-> scan_q <= CNT_W'(CLUSTER_COUNT))
    else $error("scan pointer ran past the table");

  a_close_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_CLOSE |=> !open_q && last_q == '0)
    else $error("close left the chain open");
`endif

endmodule

// ===== design/fat12_cluster_chain_allocator_top.sv =====
// Steps from acceptance to the output register: dispatch, then one step for write and close
// words, read and read-done for read words, and for allocate words a scan start, a scan of N
// entries (1 to CLUSTER_COUNT-2), one per cycle, then link and mark, or full; then emit.
// Throughput: one word at a time; the next input word is taken the cycle after the result is
// loaded into the output register, and a stalled output register holds the sequencer.
// Reset: sequencer idle, no chain open, output empty; the table is not cleared.
module fat12_cluster_chain_allocator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [fat12_pkg::ENTRY_W-1:0] entry_index_i,
  input  logic [fat12_pkg::ENTRY_W-1:0] entry_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fat12_pkg::ENTRY_W-1:0] cluster_value_o,
  output logic                          starts_chain_o,
  output logic                          table_full_o
);
  import fat12_pkg::*;

  op_e        op;
  logic       idle;
  logic       in_accept;
  logic       out_busy;
  logic       load_out;
  dp_status_t status;
  result_t    result;

  logic               out_valid_q;
  logic [ENTRY_W-1:0] cluster_value_q;
  logic               starts_chain_q;
  logic               table_full_q;

  // Take a new word only while the sequencer sits at its idle step.
  assign in_stall_o = !idle;
  assign in_accept  = in_valid_i && !in_stall_o;

  // The output register is busy while it holds a word the sink stalls.
  assign out_busy = out_valid_q && out_stall_i;
  assign load_out = (op == OP_EMIT) && !out_busy;

  fat12_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_busy),
    .status_i   (status),
    .op_o       (op),
    .idle_o     (idle)
  );

  fat12_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .capture_i     (in_accept),
    .kind_i        (kind_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .op_i          (op),
    .status_o      (status),
    .result_o      (result)
  );

  // Output valid: set on load, drop once the sink takes the word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the payload while stalled; load only when the register is free.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      cluster_value_q <= result.value;
      starts_chain_q  <= result.start;
      table_full_q    <= result.full;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cluster_value_o = cluster_value_q;
  assign starts_chain_o  = starts_chain_q;
  assign table_full_o    = table_full_q;

`ifndef SYNTHESIS
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("second word accepted while one is in flight");
`endif

endmodule
